>>> hw/rtl/bfd_pkg.sv
// Package for the box filter downscaler: widths, sizes, register indexes.
// No dependencies.
package bfd_pkg;
    localparam int MAX_IMAGE_SIDE = 4096;
    localparam int MAX_OUT_WIDTH  = 512;
    localparam int OUT_AW         = $clog2(MAX_OUT_WIDTH);
    localparam int SIDE_W         = 13;
    localparam int SUM_W          = 32;
    localparam int CNT_W          = 25;
    localparam int ACC_W          = 3 * SUM_W + CNT_W;
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAX    = 2'd2;
    localparam int CFG_W = 13;

    typedef struct packed {
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic        frame_last;
    } t_out;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in;
endpackage

>>> hw/rtl/bfd_if.sv
// Valid/ready channel interface carrying one payload item.
// No dependencies; the payload type comes in as a type parameter.
interface bfd_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/bfd_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module bfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

>>> hw/rtl/bfd_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on bfd_pkg.
module bfd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [47:0] o_quo
);
    import bfd_pkg::*;
    logic [47:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic [32:0] shifted;

    assign o_busy = (r_cnt != 6'd0);
    assign o_quo  = r_quo;

    // Shift in one numerator bit and try a subtract
    always_comb begin
        shifted = {r_rem, r_quo[47]};
        n_quo   = {r_quo[46:0], 1'b0};
        n_rem   = shifted[31:0];
        if (shifted >= {1'b0, r_den}) begin
            n_rem    = shifted[31:0] - r_den;
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_start) begin
            r_cnt <= 6'd48;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (o_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end
endmodule

>>> hw/rtl/box_filter_image_downscaler.sv
// Box filter image downscaler: control, sizing, column sum memory, averaging.
// Depends on bfd_pkg, bfd_if, bfd_ram, bfd_div.
//
// Usage: pixels enter on i_pix in raster order; one result per completed box
// (or per pixel in pass-through) leaves on o_res with its coordinates and a
// frame_last flag. Configuration writes (i_cfg_we/i_cfg_idx/i_cfg_data)
// restart the frame; the user must issue them only while no item is in
// flight; the block does not enforce this. Each write, and reset, runs a
// setup for output size and box bounds through the shared serial divider,
// then a sweep that clears all 512 entries of the column sum memory; no
// pixel is taken meanwhile. Pass-through takes a pixel, then advances.
// When scaling, a pixel inside a box column goes through read, update and
// advance; a pixel that ends a box column adds one column bound division;
// a pixel that completes a box adds three average divisions, the output
// load and the next column bound. The end of each input row adds the column
// and row bound divisions, and one more row bound division when a row band ends.
// A result waits in the output register while the receiver stalls; no pixel
// is taken while that register is full unless it is read in the same cycle.
module box_filter_image_downscaler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [bfd_pkg::CFG_W-1:0]  i_cfg_data,
    bfd_if.sink                        i_pix,
    bfd_if.source                      o_res
);
    import bfd_pkg::*;

    localparam logic [4:0] S_SZ0   = 5'd0;  // scaled side division start
    localparam logic [4:0] S_SZ1   = 5'd1;
    localparam logic [4:0] S_CB0   = 5'd2;  // column bound division start
    localparam logic [4:0] S_CB1   = 5'd3;
    localparam logic [4:0] S_RB0   = 5'd4;  // row bound division start
    localparam logic [4:0] S_RB1   = 5'd5;
    localparam logic [4:0] S_CLR   = 5'd6;
    localparam logic [4:0] S_IDLE  = 5'd7;
    localparam logic [4:0] S_RD    = 5'd8;
    localparam logic [4:0] S_UPD   = 5'd9;
    localparam logic [4:0] S_AV0   = 5'd10;
    localparam logic [4:0] S_AV1   = 5'd11;
    localparam logic [4:0] S_OUT   = 5'd12;
    localparam logic [4:0] S_ADV   = 5'd13;
    localparam logic [4:0] S_NC0   = 5'd14; // next column bound
    localparam logic [4:0] S_NC1   = 5'd15;
    localparam logic [4:0] S_NR0   = 5'd16; // next row bound
    localparam logic [4:0] S_NR1   = 5'd17;

    // Configuration registers
    logic [12:0] r_width, r_height;
    logic [9:0]  r_max;
    logic [12:0] w_eff, h_eff;
    logic [9:0]  m_eff;
    logic        scale_now;

    assign w_eff = (r_width == 13'd0) ? 13'd1 :
                   (r_width > 13'(MAX_IMAGE_SIDE)) ? 13'(MAX_IMAGE_SIDE) : r_width;
    assign h_eff = (r_height == 13'd0) ? 13'd1 :
                   (r_height > 13'(MAX_IMAGE_SIDE)) ? 13'(MAX_IMAGE_SIDE) : r_height;
    assign m_eff = (r_max > 10'(MAX_OUT_WIDTH)) ? 10'(MAX_OUT_WIDTH) : r_max;
    assign scale_now = (m_eff != 10'd0) && (w_eff > 13'(m_eff) || h_eff > 13'(m_eff));

    logic [4:0]  r_st;
    logic        r_scaling;
    logic        r_setup;
    logic [12:0] r_sw, r_sh;
    logic [11:0] r_in_col, r_in_row, r_band_col, r_band_row;
    logic [12:0] r_col_bound, r_row_bound;
    logic [OUT_AW-1:0] r_clr;
    logic [7:0]  r_red, r_green, r_blue;
    logic [1:0]  r_ch;
    logic [ACC_W-1:0] r_acc;
    logic [7:0]  r_avg [3];
    logic        r_last;
    logic        r_ovalid;
    t_out        r_odata;

    // Shared divider
    logic        div_start, div_busy;
    logic [47:0] div_num, div_quo;
    logic [31:0] div_den;

    bfd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // Column sum memory
    logic              mem_we;
    logic [OUT_AW-1:0] mem_addr;
    logic [ACC_W-1:0]  mem_wdata, mem_rdata;
    logic [SUM_W-1:0]  sum_r, sum_g, sum_b;
    logic [CNT_W-1:0]  cnt;

    bfd_ram #(.WIDTH(ACC_W), .DEPTH(MAX_OUT_WIDTH)) u_sums (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_addr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_addr),
        .o_rdata (mem_rdata)
    );

    assign mem_addr = (r_st == S_CLR) ? r_clr :
                      (r_band_col >= 12'(MAX_OUT_WIDTH)) ? OUT_AW'(MAX_OUT_WIDTH - 1)
                                                         : r_band_col[OUT_AW-1:0];
    assign sum_r = mem_rdata[ACC_W-1 -: SUM_W] + SUM_W'(r_red);
    assign sum_g = mem_rdata[ACC_W-1-SUM_W -: SUM_W] + SUM_W'(r_green);
    assign sum_b = mem_rdata[CNT_W+SUM_W-1 -: SUM_W] + SUM_W'(r_blue);
    assign cnt   = mem_rdata[CNT_W-1:0] + CNT_W'(1);

    logic col_end, box_done, last_pix, in_ok;
    assign col_end  = ({1'b0, r_in_col} + 13'd1) >= r_col_bound;
    assign box_done = col_end && (({1'b0, r_in_row} + 13'd1) >= r_row_bound);
    assign last_pix = (({1'b0, r_in_col} + 13'd1) >= w_eff) &&
                      (({1'b0, r_in_row} + 13'd1) >= h_eff);
    assign in_ok    = (r_st == S_IDLE) && (!r_ovalid || o_res.ready);

    assign i_pix.ready = in_ok;
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_odata;

    // Register write and output load decodes
    logic cfg_hit, out_load;
    assign cfg_hit  = i_cfg_we && (i_cfg_idx == REG_WIDTH || i_cfg_idx == REG_HEIGHT ||
                                   i_cfg_idx == REG_MAX);
    assign out_load = !cfg_hit &&
                      (((r_st == S_IDLE) && i_pix.valid && in_ok && !r_scaling) ||
                       ((r_st == S_OUT) && (!r_ovalid || o_res.ready)));

    // Write back accumulated sums, or clear
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        if (r_st == S_CLR) begin
            mem_we = 1'b1;
        end else if (r_st == S_UPD) begin
            mem_we = 1'b1;
            if (!box_done) begin
                mem_wdata = {sum_r, sum_g, sum_b, cnt};
            end
        end
    end

    // Divider operands by state
    logic [SUM_W-1:0] sum_sel;
    always_comb begin
        case (r_ch)
            2'd0:    sum_sel = r_acc[ACC_W-1 -: SUM_W];
            2'd1:    sum_sel = r_acc[ACC_W-1-SUM_W -: SUM_W];
            default: sum_sel = r_acc[CNT_W+SUM_W-1 -: SUM_W];
        endcase
    end
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = 32'd1;
        case (r_st)
            S_SZ0: begin
                div_start = scale_now;
                if (w_eff >= h_eff) begin
                    div_num = 48'(h_eff) * 48'(m_eff) + 48'(w_eff >> 1);
                    div_den = 32'(w_eff);
                end else begin
                    div_num = 48'(w_eff) * 48'(m_eff) + 48'(h_eff >> 1);
                    div_den = 32'(h_eff);
                end
            end
            S_CB0, S_NC0: begin
                div_start = 1'b1;
                div_num   = 48'({1'b0, r_band_col} + 13'd1) * 48'(w_eff);
                div_den   = 32'(r_sw);
            end
            S_RB0, S_NR0: begin
                div_start = 1'b1;
                div_num   = 48'({1'b0, r_band_row} + 13'd1) * 48'(h_eff);
                div_den   = 32'(r_sh);
            end
            S_AV0: begin
                div_start = 1'b1;
                div_num   = 48'(sum_sel) + 48'(r_acc[CNT_W-1:1]);
                div_den   = 32'(r_acc[CNT_W-1:0]);
            end
            default: begin
            end
        endcase
    end

    logic [12:0] q13;
    assign q13 = (div_quo > 48'd8191) ? 13'h1fff : div_quo[12:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd1;
            r_height <= 13'd1;
            r_max    <= 10'd384;
            r_st     <= S_SZ0;
            r_ovalid <= 1'b0;
            r_scaling <= 1'b0;
            r_setup  <= 1'b1;
            r_clr    <= '0;
            r_in_col <= '0; r_in_row <= '0; r_band_col <= '0; r_band_row <= '0;
            r_sw     <= 13'd1; r_sh <= 13'd1;
        end else begin
            // Release the output item when taken
            if (r_ovalid && o_res.ready && !out_load) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_hit) begin
                case (i_cfg_idx)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    default:    r_max    <= i_cfg_data[9:0];
                endcase
                r_st <= S_SZ0;
            end else begin
                case (r_st)
                    S_SZ0: begin
                        r_in_col <= '0; r_in_row <= '0;
                        r_band_col <= '0; r_band_row <= '0;
                        r_clr <= '0;
                        r_setup <= 1'b1;
                        r_scaling <= scale_now;
                        if (scale_now) begin
                            r_sw <= (w_eff >= h_eff) ? 13'(m_eff) : w_eff;
                            r_sh <= (w_eff >= h_eff) ? h_eff : 13'(m_eff);
                            r_st <= S_SZ1;
                        end else begin
                            r_sw <= w_eff;
                            r_sh <= h_eff;
                            r_st <= S_CB0;
                        end
                    end
                    S_SZ1: begin
                        if (!div_busy && !div_start) begin
                            if (w_eff >= h_eff) r_sh <= (q13 == 13'd0) ? 13'd1 : q13;
                            else                r_sw <= (q13 == 13'd0) ? 13'd1 : q13;
                            r_st <= S_CB0;
                        end
                    end
                    S_CB0: r_st <= S_CB1;
                    S_CB1: if (!div_busy) begin
                        r_col_bound <= q13;
                        r_st <= S_RB0;
                    end
                    S_RB0: r_st <= S_RB1;
                    // Sweep the sum memory only on setup, not at row ends
                    S_RB1: if (!div_busy) begin
                        r_row_bound <= q13;
                        r_st <= r_setup ? S_CLR : S_IDLE;
                    end
                    S_CLR: begin
                        r_clr <= r_clr + OUT_AW'(1);
                        if (r_clr == OUT_AW'(MAX_OUT_WIDTH - 1)) begin
                            r_st    <= S_IDLE;
                            r_setup <= 1'b0;
                        end
                    end
                    S_IDLE: if (i_pix.valid && in_ok) begin
                        r_red   <= i_pix.data.red;
                        r_green <= i_pix.data.green;
                        r_blue  <= i_pix.data.blue;
                        r_last  <= last_pix;
                        if (!r_scaling) begin
                            r_odata  <= '{i_pix.data.red, i_pix.data.green, i_pix.data.blue,
                                          r_in_col, r_in_row, last_pix};
                            r_ovalid <= 1'b1;
                            r_st     <= S_ADV;
                        end else begin
                            r_st <= S_RD;
                        end
                    end
                    S_RD: r_st <= S_UPD;
                    S_UPD: begin
                        r_acc <= {sum_r, sum_g, sum_b, cnt};
                        r_ch  <= 2'd0;
                        if (box_done)     r_st <= S_AV0;
                        else if (col_end) r_st <= S_NC0;
                        else              r_st <= S_ADV;
                        if (col_end) r_band_col <= r_band_col + 12'd1;
                    end
                    S_AV0: r_st <= S_AV1;
                    S_AV1: if (!div_busy) begin
                        r_avg[r_ch] <= div_quo[7:0];
                        if (r_ch == 2'd2) begin
                            r_st <= S_OUT;
                        end else begin
                            r_ch <= r_ch + 2'd1;
                            r_st <= S_AV0;
                        end
                    end
                    S_OUT: if (!r_ovalid || o_res.ready) begin
                        r_odata  <= '{r_avg[0], r_avg[1], r_avg[2],
                                      r_band_col - 12'd1, r_band_row, r_last};
                        r_ovalid <= 1'b1;
                        r_st     <= S_NC0;
                    end
                    S_NC0: r_st <= S_NC1;
                    S_NC1: if (!div_busy) begin
                        r_col_bound <= q13;
                        r_st <= S_ADV;
                    end
                    // Advance the input position; wrap rows, bands and frames
                    S_ADV: begin
                        if ({1'b0, r_in_col} + 13'd1 >= w_eff) begin
                            r_in_col   <= '0;
                            r_band_col <= '0;
                            if ({1'b0, r_in_row} + 13'd1 >= h_eff) begin
                                r_in_row   <= '0;
                                r_band_row <= '0;
                                r_st       <= S_CB0;
                            end else if ({1'b0, r_in_row} + 13'd1 >= r_row_bound) begin
                                r_in_row   <= r_in_row + 12'd1;
                                r_band_row <= r_band_row + 12'd1;
                                r_st       <= S_NR0;
                            end else begin
                                r_in_row <= r_in_row + 12'd1;
                                r_st     <= S_CB0;
                            end
                        end else begin
                            r_in_col <= r_in_col + 12'd1;
                            r_st     <= S_IDLE;
                        end
                    end
                    S_NR0: r_st <= S_NR1;
                    S_NR1: if (!div_busy) begin
                        r_row_bound <= q13;
                        r_st <= S_CB0;
                    end
                    default: r_st <= S_SZ0;
                endcase
            end
        end
    end
endmodule

>>> hw/rtl/bfd_chk.sv
// Port-level checker for the box filter downscaler, bound to the top level.
// Depends on bfd_pkg and box_filter_image_downscaler.
module bfd_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic [1:0] i_cfg_idx,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_last
);
    import bfd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");
    a_no_take_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !in_ready)
        else $error("pixel taken during setup");
    a_no_take_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx <= REG_MAX) |=> !in_ready)
        else $error("pixel taken right after a register write");
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("output valid after reset");
    a_last_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_last && !out_ready |=> out_last)
        else $error("frame_last changed while stalled");
endmodule

bind box_filter_image_downscaler bfd_chk u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_cfg_we  (i_cfg_we),
    .i_cfg_idx (i_cfg_idx),
    .in_ready  (i_pix.ready),
    .out_valid (o_res.valid),
    .out_ready (o_res.ready),
    .out_last  (o_res.data.frame_last)
);

>>> tb/sv/tb_bfd_checker.sv
// Checker for the box filter downscaler: watches pixels, results and register writes.
// Depends on bfd_pkg and bfd_if; predicts each result and compares it in order.
module tb_bfd_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [bfd_pkg::CFG_W-1:0]  i_cfg_data,
    bfd_if                             pix_mon,
    bfd_if                             res_mon,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_result_count,
    output int                         o_pixel_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import bfd_pkg::*;

    // register copies and downscaler state
    int unsigned reg_width, reg_height, reg_max;
    int unsigned col_pos, row_pos, box_col, box_row;
    int unsigned col_end, row_end, dst_width, dst_height;
    bit          is_scaling;
    logic [31:0] red_acc   [MAX_OUT_WIDTH];
    logic [31:0] green_acc [MAX_OUT_WIDTH];
    logic [31:0] blue_acc  [MAX_OUT_WIDTH];
    logic [24:0] pix_cnt   [MAX_OUT_WIDTH];
    t_out        expected_px[$];

    function automatic int unsigned clamp_side(int unsigned v);
        if (v == 0) return 1;
        if (v > MAX_IMAGE_SIDE) return MAX_IMAGE_SIDE;
        return v;
    endfunction

    function automatic int unsigned edge_of_box(int unsigned k, int unsigned full,
                                                int unsigned scaled);
        longint unsigned p;
        p = longint'(k + 1) * full;
        return int'(p / scaled);
    endfunction

    function automatic logic [7:0] rounded_mean(logic [31:0] sum, logic [24:0] n);
        longint unsigned q;
        if (n == 0) return 8'd0;
        q = (longint'(sum) + n / 2) / n;
        return q[7:0];
    endfunction

    // recompute output size and clear the column sums
    task automatic start_frame();
        int unsigned w, h, m;
        w = clamp_side(reg_width);
        h = clamp_side(reg_height);
        m = (reg_max > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : reg_max;
        dst_width  = w;
        dst_height = h;
        is_scaling = 0;
        if (m > 0 && (w > m || h > m)) begin
            is_scaling = 1;
            if (w >= h) begin
                dst_width  = m;
                dst_height = int'((longint'(h) * m + w / 2) / w);
            end else begin
                dst_height = m;
                dst_width  = int'((longint'(w) * m + h / 2) / h);
            end
            if (dst_width < 1) dst_width = 1;
            if (dst_height < 1) dst_height = 1;
        end
        col_pos = 0; row_pos = 0; box_col = 0; box_row = 0;
        col_end = edge_of_box(0, w, dst_width);
        row_end = edge_of_box(0, h, dst_height);
        for (int i = 0; i < MAX_OUT_WIDTH; i++) begin
            red_acc[i] = 0; green_acc[i] = 0; blue_acc[i] = 0; pix_cnt[i] = 0;
        end
    endtask

    // advance the downscaler by one pixel, queue a result if a box closes (every pixel in pass-through)
    task automatic take_pixel(t_in px);
        int unsigned w, h, k;
        bit          frame_end;
        t_out        r;
        w = clamp_side(reg_width);
        h = clamp_side(reg_height);
        frame_end = (col_pos + 1 >= w) && (row_pos + 1 >= h);
        if (!is_scaling) begin
            r.out_red = px.red; r.out_green = px.green; r.out_blue = px.blue;
            r.out_x = col_pos[11:0]; r.out_y = row_pos[11:0];
            r.frame_last = frame_end;
            expected_px.push_back(r);
        end else begin
            k = (box_col < MAX_OUT_WIDTH) ? box_col : MAX_OUT_WIDTH - 1;
            red_acc[k]   += px.red;
            green_acc[k] += px.green;
            blue_acc[k]  += px.blue;
            pix_cnt[k]   += 1;
            if (col_pos + 1 >= col_end) begin
                if (row_pos + 1 >= row_end) begin
                    r.out_red   = rounded_mean(red_acc[k], pix_cnt[k]);
                    r.out_green = rounded_mean(green_acc[k], pix_cnt[k]);
                    r.out_blue  = rounded_mean(blue_acc[k], pix_cnt[k]);
                    r.out_x = box_col[11:0]; r.out_y = box_row[11:0];
                    r.frame_last = frame_end;
                    expected_px.push_back(r);
                    red_acc[k] = 0; green_acc[k] = 0; blue_acc[k] = 0; pix_cnt[k] = 0;
                end
                box_col++;
                col_end = edge_of_box(box_col, w, dst_width);
            end
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            box_col = 0;
            col_end = edge_of_box(0, w, dst_width);
            row_pos++;
            if (row_pos >= row_end) begin
                box_row++;
                row_end = edge_of_box(box_row, h, dst_height);
            end
            if (row_pos >= h) begin
                row_pos = 0;
                box_row = 0;
                row_end = edge_of_box(0, h, dst_height);
            end
        end
    endtask

    // follow reset, register writes, pixels and results at each rising edge
    always @(posedge i_clk) begin
        t_out got, want;
        if (!i_rst_n) begin
            reg_width = 1; reg_height = 1; reg_max = 384;
            start_frame();
            expected_px.delete();
            o_fail_count   <= 0;
            o_result_count <= 0;
            o_pixel_count  <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_WIDTH) begin
                    reg_width = i_cfg_data; start_frame();
                end else if (i_cfg_idx == REG_HEIGHT) begin
                    reg_height = i_cfg_data; start_frame();
                end else if (i_cfg_idx == REG_MAX) begin
                    reg_max = i_cfg_data[9:0]; start_frame();
                end
            end
            if (pix_mon.valid && pix_mon.ready) begin
                take_pixel(pix_mon.data);
                o_pixel_count <= o_pixel_count + 1;
            end
            if (res_mon.valid && res_mon.ready) begin
                got = res_mon.data;
                o_result_count <= o_result_count + 1;
                if (expected_px.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected result %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_px.pop_front();
                    if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
                        got.out_blue !== want.out_blue || got.out_x !== want.out_x ||
                        got.out_y !== want.out_y || got.frame_last !== want.frame_last) begin
                        if (o_fail_count < 10)
                            $display("ERROR: mismatch expected %p actual %p", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_px.size();
    end
endmodule

>>> tb/sv/tb_box_filter_image_downscaler.sv
// Top of the downscaler testbench: clock, reset, pixel stimulus, verdict.
// Depends on bfd_pkg, bfd_if, box_filter_image_downscaler and tb_bfd_checker.
module tb_box_filter_image_downscaler;
    timeunit 1ns;
    timeprecision 1ps;
    import bfd_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SETUP_WAIT  = 1500;
    localparam int DRAIN_WAIT  = 600;
    localparam int PHASE_ITEMS = 300;
    localparam logic [1:0] REG_NONE = 2'd3;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_idx;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count, pending, result_count, pixel_count;
    int               idle_cycles;
    bit               sender_gaps, receiver_stalls;
    int               idle_pct;
    int               frame_count;

    bfd_if #(.T(t_in))  pix_ch ();
    bfd_if #(.T(t_out)) res_ch ();

    box_filter_image_downscaler u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_ch.sink),
        .o_res      (res_ch.source)
    );

    tb_bfd_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .pix_mon        (pix_ch),
        .res_mon        (res_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_pixel_count  (pixel_count)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // random backpressure on the result side
    always @(negedge i_clk) begin
        res_ch.ready <= receiver_stalls ? ($urandom_range(99) >= idle_pct) : 1'b1;
    end

    // end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // write one register, then hold off while the block sets up
    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        repeat (SETUP_WAIT) @(negedge i_clk);
    endtask

    // wait for every predicted result, then let any box still in work finish
    task automatic drain();
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_image(int unsigned w, int unsigned h, int unsigned m);
        drain();
        write_reg(REG_WIDTH, w[CFG_W-1:0]);
        write_reg(REG_HEIGHT, h[CFG_W-1:0]);
        write_reg(REG_MAX, m[CFG_W-1:0]);
    endtask

    // drive one pixel, starting and ending at a falling edge
    task automatic send_pixel(t_in px);
        if (sender_gaps) begin
            while ($urandom_range(99) < idle_pct) begin
                pix_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        pix_ch.valid <= 1'b1;
        pix_ch.data  <= px;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(int n);
        t_in px;
        for (int i = 0; i < n; i++) begin
            px.red   = $urandom_range(255);
            px.green = $urandom_range(255);
            px.blue  = $urandom_range(255);
            send_pixel(px);
        end
        pix_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_flat(int n, logic [7:0] v);
        t_in px;
        px = '{red: v, green: ~v, blue: v};
        for (int i = 0; i < n; i++) send_pixel(px);
        pix_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned w, h, m;
        int          sent;
        int          cut;
        i_rst_n = 1'b0;
        cfg_we = 1'b0; cfg_idx = REG_WIDTH; cfg_data = '0;
        pix_ch.valid = 1'b0; pix_ch.data = '0;
        res_ch.ready = 1'b1;
        sender_gaps = 0; receiver_stalls = 0;
        idle_pct = 63;
        idle_cycles = 0;
        frame_count = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (SETUP_WAIT) @(negedge i_clk);

        // directed: reset size, zero sizes, extremes, both scaling directions
        send_flat(1, 8'hff);
        send_flat(1, 8'h00);
        set_image(0, 0, 0);
        send_flat(2, 8'h80);
        set_image(3, 2, 0);
        send_flat(3, 8'hff);
        send_flat(3, 8'h00);
        set_image(5, 4, 2);
        send_random(20);
        set_image(2, 7, 3);
        send_flat(14, 8'hff);
        drain();
        write_reg(REG_NONE, 13'h1fff);
        send_random(14);

        // random phases: none, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            sender_gaps     = (phase == 1) || (phase == 3);
            receiver_stalls = (phase == 2) || (phase == 3);
            idle_pct        = (phase == 3) ? 19 : 63;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                w = $urandom_range(1, 24);
                h = $urandom_range(1, 24);
                m = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 12);
                set_image(w, h, m);
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(9) == 0) begin
                        // cut a frame short; the next write restarts it
                        cut = $urandom_range(1, w * h);
                        send_random(cut);
                        sent += cut;
                        break;
                    end
                    send_random(w * h);
                    sent += w * h;
                    frame_count++;
                end
            end
        end

        // largest sizes, clamped registers and a max side above the limit
        sender_gaps = 0; receiver_stalls = 0;
        set_image(13'h1fff, 1, 1023);
        send_random(100);
        set_image(1, 13'h1fff, 512);
        send_random(100);
        set_image(600, 1, 512);
        send_random(200);
        drain();

        $display("Sent %0d pixels in %0d random frames, checked %0d results.",
                 pixel_count, frame_count, result_count);
        $display("Covered pass-through, both scaling directions, clamped sizes and stalls.");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/bfd_pkg.sv
hw/rtl/bfd_if.sv
hw/rtl/bfd_ram.sv
hw/rtl/bfd_div.sv
hw/rtl/box_filter_image_downscaler.sv
hw/rtl/bfd_chk.sv
tb/sv/tb_bfd_checker.sv
tb/sv/tb_box_filter_image_downscaler.sv
